[design/rdf_pkg.sv]
package rdf_pkg;

    localparam logic [7:0] FCGI_VERSION = 8'd1;

    localparam logic [7:0] REC_BEGIN  = 8'd1;
    localparam logic [7:0] REC_ABORT  = 8'd2;
    localparam logic [7:0] REC_PARAMS = 8'd4;
    localparam logic [7:0] REC_STDIN  = 8'd5;

    localparam logic [2:0] HDR_VERSION  = 3'd0;
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_ID_HI    = 3'd2;
    localparam logic [2:0] HDR_ID_LO    = 3'd3;
    localparam logic [2:0] HDR_LEN_HI   = 3'd4;
    localparam logic [2:0] HDR_LEN_LO   = 3'd5;
    localparam logic [2:0] HDR_PADDING  = 3'd6;
    localparam logic [2:0] HDR_RESERVED = 3'd7;

    localparam logic [2:0] BODY_ROLE_HI = 3'd0;
    localparam logic [2:0] BODY_ROLE_LO = 3'd1;
    localparam logic [2:0] BODY_FLAGS   = 3'd2;
    localparam logic [2:0] BODY_LAST    = 3'd7;

    localparam logic [3:0] CLS_HEADER     = 4'd0;
    localparam logic [3:0] CLS_BEGIN_BODY = 4'd1;
    localparam logic [3:0] CLS_NAME_LEN   = 4'd2;
    localparam logic [3:0] CLS_VALUE_LEN  = 4'd3;
    localparam logic [3:0] CLS_NAME       = 4'd4;
    localparam logic [3:0] CLS_VALUE      = 4'd5;
    localparam logic [3:0] CLS_STDIN      = 4'd6;
    localparam logic [3:0] CLS_IGNORED    = 4'd7;
    localparam logic [3:0] CLS_PADDING    = 4'd8;
    localparam logic [3:0] CLS_HALTED     = 4'd9;

    localparam logic [3:0] EVT_NONE       = 4'd0;
    localparam logic [3:0] EVT_BEGUN      = 4'd1;
    localparam logic [3:0] EVT_DUPLICATE  = 4'd2;
    localparam logic [3:0] EVT_FULL       = 4'd3;
    localparam logic [3:0] EVT_ABORTED    = 4'd4;
    localparam logic [3:0] EVT_PARAMS     = 4'd5;
    localparam logic [3:0] EVT_PARAMS_END = 4'd6;
    localparam logic [3:0] EVT_STDIN      = 4'd7;
    localparam logic [3:0] EVT_STDIN_END  = 4'd8;
    localparam logic [3:0] EVT_UNK_TYPE   = 4'd9;
    localparam logic [3:0] EVT_UNK_ID     = 4'd10;

    localparam int TDATA_W       = 120;
    localparam int OUT_EVT_LSB   = 94;
    localparam int OUT_VERR_BIT  = 118;

    typedef enum logic [3:0] {
        PH_NAME_LEN  = 4'b0001,
        PH_VALUE_LEN = 4'b0010,
        PH_NAME      = 4'b0100,
        PH_VALUE     = 4'b1000
    } param_phase_t;

    typedef struct packed {
        logic        alloc;
        logic        clear;
        logic [15:0] id;
    } tbl_cmd_t;

    typedef struct packed {
        logic hit;
        logic free_found;
    } tbl_status_t;

    typedef struct packed {
        logic [3:0]  byte_class;
        logic [7:0]  record_type;
        logic [15:0] request_id;
        logic [7:0]  byte_out;
        logic [30:0] name_length;
        logic [30:0] value_length;
        logic        record_done;
        logic [3:0]  record_event;
        logic [2:0]  slot;
        logic [15:0] role;
        logic        keep_conn;
        logic        version_error;
    } rdf_result_t;

endpackage

[design/rdf_table.sv]
module rdf_table import rdf_pkg::*; #(
    parameter int MAX_REQUESTS = 8,
    parameter int SLOT_W       = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       lookup_id,
    input  tbl_cmd_t          cmd,
    input  logic [SLOT_W-1:0] cmd_slot,
    output tbl_status_t       status,
    output logic [SLOT_W-1:0] hit_slot,
    output logic [SLOT_W-1:0] free_slot
);

    logic [MAX_REQUESTS-1:0] valid_reg;
    logic [MAX_REQUESTS-1:0] valid_next;
    logic [15:0]             id_mem [MAX_REQUESTS];

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear) begin
            valid_next[cmd_slot] = 1'b0;
        end
        if (cmd.alloc) begin
            valid_next[cmd_slot] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            id_mem[cmd_slot] <= cmd.id;
        end
    end

    // scan downward so the lowest matching and lowest free entries win
    always_comb begin
        status    = '0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = MAX_REQUESTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && id_mem[i] == lookup_id) begin
                status.hit = 1'b1;
                hit_slot   = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                status.free_found = 1'b1;
                free_slot         = SLOT_W'(i);
            end
        end
    end

endmodule

[design/rdf_parser.sv]
module rdf_parser import rdf_pkg::*; #(
    parameter int SLOT_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  tbl_status_t       tbl_status,
    input  logic [SLOT_W-1:0] tbl_hit_slot,
    input  logic [SLOT_W-1:0] tbl_free_slot,
    output logic [15:0]       lookup_id,
    output tbl_cmd_t          tbl_cmd,
    output logic [SLOT_W-1:0] tbl_cmd_slot,
    output rdf_result_t       result
);

    logic [3:0]        hdr_idx_reg, hdr_idx_next;
    logic [7:0]        type_reg, type_next;
    logic [15:0]       id_reg, id_next;
    logic [15:0]       content_left_reg, content_left_next;
    logic [7:0]        padding_left_reg, padding_left_next;
    param_phase_t      phase_reg, phase_next;
    logic [30:0]       len_acc_reg, len_acc_next;
    logic [1:0]        len_seen_reg, len_seen_next;
    logic [30:0]       name_left_reg, name_left_next;
    logic [30:0]       value_left_reg, value_left_next;
    logic [30:0]       key_len_reg, key_len_next;
    logic [30:0]       value_len_reg, value_len_next;
    logic [2:0]        body_idx_reg, body_idx_next;
    logic [15:0]       role_reg, role_next;
    logic              keep_reg, keep_next;
    logic              halted_reg, halted_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic              empty_reg, empty_next;

    logic [3:0]        cls;
    logic [3:0]        evt;
    logic              ends;
    logic              len_done;
    logic [30:0]       len_val;
    tbl_cmd_t          cmd;
    logic [SLOT_W-1:0] cmd_slot;
    logic [SLOT_W-1:0] slot_out;
    logic [SLOT_W+2:0] slot_ext;

    assign lookup_id = id_reg;

    always_comb begin
        hdr_idx_next      = hdr_idx_reg;
        type_next         = type_reg;
        id_next           = id_reg;
        content_left_next = content_left_reg;
        padding_left_next = padding_left_reg;
        phase_next        = phase_reg;
        len_acc_next      = len_acc_reg;
        len_seen_next     = len_seen_reg;
        name_left_next    = name_left_reg;
        value_left_next   = value_left_reg;
        key_len_next      = key_len_reg;
        value_len_next    = value_len_reg;
        body_idx_next     = body_idx_reg;
        role_next         = role_reg;
        keep_next         = keep_reg;
        halted_next       = halted_reg;
        slot_next         = slot_reg;
        hit_next          = hit_reg;
        empty_next        = empty_reg;
        cls               = CLS_HEADER;
        evt               = EVT_NONE;
        ends              = 1'b0;
        len_done          = 1'b0;
        len_val           = '0;
        cmd               = '0;
        cmd_slot          = '0;

        if (halted_reg) begin
            cls = CLS_HALTED;
        end else if (!hdr_idx_reg[3]) begin
            case (hdr_idx_reg[2:0])
                HDR_VERSION: begin
                    if (data_byte != FCGI_VERSION) begin
                        halted_next = 1'b1;
                        cls         = CLS_HALTED;
                    end else begin
                        type_next         = '0;
                        id_next           = '0;
                        content_left_next = '0;
                        padding_left_next = '0;
                    end
                end
                HDR_TYPE:    type_next = data_byte;
                HDR_ID_HI:   id_next = {data_byte, 8'h00};
                HDR_ID_LO:   id_next = {id_reg[15:8], data_byte};
                HDR_LEN_HI:  content_left_next = {data_byte, 8'h00};
                HDR_LEN_LO:  content_left_next = {content_left_reg[15:8], data_byte};
                HDR_PADDING: padding_left_next = data_byte;
                HDR_RESERVED: begin
                    phase_next      = PH_NAME_LEN;
                    len_seen_next   = '0;
                    len_acc_next    = '0;
                    name_left_next  = '0;
                    value_left_next = '0;
                    key_len_next    = '0;
                    value_len_next  = '0;
                    body_idx_next   = '0;
                    role_next       = '0;
                    keep_next       = 1'b0;
                    empty_next      = (content_left_reg == '0);
                    hit_next        = tbl_status.hit;
                    if (tbl_status.hit) begin
                        slot_next = tbl_hit_slot;
                    end else if (tbl_status.free_found) begin
                        slot_next = tbl_free_slot;
                    end else begin
                        slot_next = '0;
                    end
                    ends = (content_left_reg == '0) && (padding_left_reg == '0);
                end
                default: ;
            endcase
            if (!halted_next) begin
                hdr_idx_next = hdr_idx_reg + 4'd1;
            end
        end else begin
            if (content_left_reg != '0) begin
                content_left_next = content_left_reg - 16'd1;
                case (type_reg)
                    REC_BEGIN: begin
                        cls = CLS_BEGIN_BODY;
                        case (body_idx_reg)
                            BODY_ROLE_HI: role_next = {data_byte, 8'h00};
                            BODY_ROLE_LO: role_next = {role_reg[15:8], data_byte};
                            BODY_FLAGS:   keep_next = data_byte[0];
                            default: ;
                        endcase
                        if (body_idx_reg != BODY_LAST) begin
                            body_idx_next = body_idx_reg + 3'd1;
                        end
                    end
                    REC_PARAMS: begin
                        if (!hit_reg) begin
                            cls = CLS_IGNORED;
                        end else if (phase_reg == PH_NAME) begin
                            cls            = CLS_NAME;
                            name_left_next = name_left_reg - 31'd1;
                            if (name_left_next == '0) begin
                                phase_next = (value_left_reg != '0) ? PH_VALUE : PH_NAME_LEN;
                            end
                        end else if (phase_reg == PH_VALUE) begin
                            cls             = CLS_VALUE;
                            value_left_next = value_left_reg - 31'd1;
                            if (value_left_next == '0) begin
                                phase_next = PH_NAME_LEN;
                            end
                        end else begin
                            cls = (phase_reg == PH_NAME_LEN) ? CLS_NAME_LEN : CLS_VALUE_LEN;
                            if (len_seen_reg == 2'd0 && !data_byte[7]) begin
                                len_val  = {23'd0, data_byte};
                                len_done = 1'b1;
                            end else if (len_seen_reg == 2'd0) begin
                                len_acc_next  = {24'd0, data_byte[6:0]};
                                len_seen_next = 2'd1;
                            end else begin
                                len_acc_next = {len_acc_reg[22:0], data_byte};
                                if (len_seen_reg == 2'd3) begin
                                    len_val       = len_acc_next;
                                    len_done      = 1'b1;
                                    len_seen_next = 2'd0;
                                end else begin
                                    len_seen_next = len_seen_reg + 2'd1;
                                end
                            end
                            if (len_done) begin
                                if (phase_reg == PH_NAME_LEN) begin
                                    key_len_next   = len_val;
                                    name_left_next = len_val;
                                    value_len_next = '0;
                                    phase_next     = PH_VALUE_LEN;
                                end else begin
                                    value_len_next  = len_val;
                                    value_left_next = len_val;
                                    if (name_left_reg != '0) begin
                                        phase_next = PH_NAME;
                                    end else if (len_val != '0) begin
                                        phase_next = PH_VALUE;
                                    end else begin
                                        phase_next = PH_NAME_LEN;
                                    end
                                end
                            end
                        end
                    end
                    REC_STDIN: cls = hit_reg ? CLS_STDIN : CLS_IGNORED;
                    default:   cls = CLS_IGNORED;
                endcase
            end else begin
                cls = CLS_PADDING;
                if (padding_left_reg != '0) begin
                    padding_left_next = padding_left_reg - 8'd1;
                end
            end
            ends = (content_left_next == '0) && (padding_left_next == '0);
        end

        if (ends) begin
            hdr_idx_next = '0;
            case (type_reg)
                REC_BEGIN: begin
                    if (hit_next) begin
                        cmd.clear = 1'b1;
                        cmd_slot  = slot_next;
                        evt       = EVT_DUPLICATE;
                    end else if (!tbl_status.free_found) begin
                        evt = EVT_FULL;
                    end else begin
                        slot_next = tbl_free_slot;
                        cmd.alloc = 1'b1;
                        cmd.id    = id_reg;
                        cmd_slot  = tbl_free_slot;
                        evt       = EVT_BEGUN;
                    end
                end
                REC_ABORT:  evt = hit_next ? EVT_ABORTED : EVT_UNK_ID;
                REC_PARAMS: begin
                    if (!hit_next) begin
                        evt = EVT_UNK_ID;
                    end else begin
                        evt = empty_next ? EVT_PARAMS_END : EVT_PARAMS;
                    end
                end
                REC_STDIN: begin
                    if (!hit_next) begin
                        evt = EVT_UNK_ID;
                    end else begin
                        evt = empty_next ? EVT_STDIN_END : EVT_STDIN;
                    end
                end
                default: evt = EVT_UNK_TYPE;
            endcase
        end
    end

    always_comb begin
        if (evt == EVT_FULL || evt == EVT_UNK_TYPE || evt == EVT_UNK_ID || halted_next) begin
            slot_out = '0;
        end else begin
            slot_out = slot_next;
        end
        slot_ext = {3'b000, slot_out};
    end

    assign tbl_cmd      = step ? cmd : '0;
    assign tbl_cmd_slot = cmd_slot;

    always_comb begin
        result.byte_class    = cls;
        result.record_type   = type_next;
        result.request_id    = id_next;
        result.byte_out      = data_byte;
        result.name_length   = halted_next ? '0 : key_len_next;
        result.value_length  = halted_next ? '0 : value_len_next;
        result.record_done   = ends;
        result.record_event  = evt;
        result.slot          = slot_ext[2:0];
        result.role          = halted_next ? '0 : role_next;
        result.keep_conn     = halted_next ? 1'b0 : keep_next;
        result.version_error = halted_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_idx_reg      <= '0;
            type_reg         <= '0;
            id_reg           <= '0;
            content_left_reg <= '0;
            padding_left_reg <= '0;
            phase_reg        <= PH_NAME_LEN;
            len_acc_reg      <= '0;
            len_seen_reg     <= '0;
            name_left_reg    <= '0;
            value_left_reg   <= '0;
            key_len_reg      <= '0;
            value_len_reg    <= '0;
            body_idx_reg     <= '0;
            role_reg         <= '0;
            keep_reg         <= 1'b0;
            halted_reg       <= 1'b0;
            slot_reg         <= '0;
            hit_reg          <= 1'b0;
            empty_reg        <= 1'b0;
        end else if (step) begin
            hdr_idx_reg      <= hdr_idx_next;
            type_reg         <= type_next;
            id_reg           <= id_next;
            content_left_reg <= content_left_next;
            padding_left_reg <= padding_left_next;
            phase_reg        <= phase_next;
            len_acc_reg      <= len_acc_next;
            len_seen_reg     <= len_seen_next;
            name_left_reg    <= name_left_next;
            value_left_reg   <= value_left_next;
            key_len_reg      <= key_len_next;
            value_len_reg    <= value_len_next;
            body_idx_reg     <= body_idx_next;
            role_reg         <= role_next;
            keep_reg         <= keep_next;
            halted_reg       <= halted_next;
            slot_reg         <= slot_next;
            hit_reg          <= hit_next;
            empty_reg        <= empty_next;
        end
    end

endmodule

[design/fastcgi_record_deframer_core.sv]
// channel   direction  tvalid/tready        payload
// s_        in         s_tvalid/s_tready    s_tdata: data_byte
// m_        out        m_tvalid/m_tready    m_tdata, m_tlast: record_done,
//                                           m_tuser: byte_class
//
// One byte per cycle sustained while m_tready is high; each byte passes the input
// register, then the result register. The request table compare runs in parallel over all slots.
// aresetn is synchronous and clears parser state and all table valid bits together,
// with no clearing pass.
// With m_tready low the result holds and the input register takes at most one more byte.
module fastcgi_record_deframer_core import rdf_pkg::*; #(
    parameter int MAX_REQUESTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] record_type, [23:8] request_id, [31:24] byte_out,
    // [62:32] name_length, [93:63] value_length, [97:94] record_event,
    // [100:98] slot, [116:101] role, [117] keep_conn,
    // [118] version_error, [119] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,   // record_done
    output logic [3:0]         m_tuser    // [3:0] byte_class
);

    localparam int SLOT_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    rdf_result_t       res_reg;
    rdf_result_t       res;
    logic              advance;

    logic [15:0]       lookup_id;
    tbl_cmd_t          tbl_cmd;
    logic [SLOT_W-1:0] tbl_cmd_slot;
    tbl_status_t       tbl_status;
    logic [SLOT_W-1:0] tbl_hit_slot;
    logic [SLOT_W-1:0] tbl_free_slot;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    rdf_parser #(
        .SLOT_W (SLOT_W)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .tbl_status    (tbl_status),
        .tbl_hit_slot  (tbl_hit_slot),
        .tbl_free_slot (tbl_free_slot),
        .lookup_id     (lookup_id),
        .tbl_cmd       (tbl_cmd),
        .tbl_cmd_slot  (tbl_cmd_slot),
        .result        (res)
    );

    rdf_table #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .SLOT_W       (SLOT_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lookup_id (lookup_id),
        .cmd       (tbl_cmd),
        .cmd_slot  (tbl_cmd_slot),
        .status    (tbl_status),
        .hit_slot  (tbl_hit_slot),
        .free_slot (tbl_free_slot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.record_done;
    assign m_tuser  = res_reg.byte_class;
    assign m_tdata  = {1'b0, res_reg.version_error, res_reg.keep_conn, res_reg.role,
                       res_reg.slot, res_reg.record_event, res_reg.value_length,
                       res_reg.name_length, res_reg.byte_out, res_reg.request_id,
                       res_reg.record_type};

endmodule

[design/rdf_checker.sv]
module rdf_checker import rdf_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic [3:0]         m_tuser
);

    logic verr;
    logic [3:0] evt;

    assign verr = m_tdata[OUT_VERR_BIT];
    assign evt  = m_tdata[OUT_EVT_LSB +: 4];

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled request changed");

    a_halted_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && verr |-> m_tuser == CLS_HALTED && !m_tlast)
        else $error("version error without halted class");

    a_event_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> evt == EVT_NONE)
        else $error("event outside record end");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind fastcgi_record_deframer_core rdf_checker u_rdf_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import rdf_pkg::*;

    localparam int N_SLOTS      = 8;
    localparam int RANDOM_BYTES = 1830;
    localparam int N_OPENING    = 27;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [3:0] cls;
        logic       last;
        logic [3:0] evt;
    } stim_row_t;

    localparam stim_row_t OPENING [N_OPENING] = '{
        '{8'h01,      1'b1, CLS_HEADER,     1'b0, EVT_NONE},
        '{REC_BEGIN,  1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'hFF,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'hFF,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h02,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h01,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b1, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b1, CLS_BEGIN_BODY, 1'b0, EVT_NONE},
        '{8'h01,      1'b1, CLS_BEGIN_BODY, 1'b0, EVT_NONE},
        '{8'h00,      1'b1, CLS_PADDING,    1'b1, EVT_BEGUN},
        '{8'h01,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{REC_PARAMS, 1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'hFF,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'hFF,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b1, CLS_HEADER,     1'b1, EVT_PARAMS_END},
        '{8'h01,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'hFF,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'h00,      1'b0, CLS_HEADER,     1'b0, EVT_NONE},
        '{8'hFF,      1'b1, CLS_HEADER,     1'b1, EVT_UNK_TYPE}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic [3:0]         m_tuser;

    fastcgi_record_deframer_core #(
        .MAX_REQUESTS(N_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // parser state
    logic [3:0]   hdr_idx;
    logic [7:0]   cur_type;
    logic [15:0]  cur_id;
    logic [15:0]  content_left;
    logic [7:0]   pad_left;
    param_phase_t phase;
    logic [31:0]  len_acc;
    logic [1:0]   len_seen;
    logic [30:0]  name_left;
    logic [30:0]  value_left;
    logic [30:0]  key_len;
    logic [30:0]  value_len;
    logic [2:0]   body_idx;
    logic [15:0]  role_acc;
    logic         keep;
    logic         halted;
    logic [2:0]   cur_slot;
    logic         hit;
    logic         empty_body;
    logic         entry_valid [N_SLOTS];
    logic [15:0]  entry_id [N_SLOTS];

    rdf_result_t  pending_results [$];
    int           fail_count;
    int           bytes_checked;
    int           records_closed;
    bit           events_seen [16];

    function automatic int free_slot();
        for (int i = 0; i < N_SLOTS; i++)
            if (!entry_valid[i]) return i;
        return -1;
    endfunction

    function automatic rdf_result_t parse_byte(input logic [7:0] b);
        rdf_result_t r;
        logic        ends;
        logic        complete;
        logic [3:0]  cls;
        logic [3:0]  evt;
        logic [30:0] val;
        int          f;
        cls = CLS_HEADER;
        evt = EVT_NONE;
        ends = 1'b0;
        complete = 1'b0;
        val = '0;
        if (halted) begin
            cls = CLS_HALTED;
        end else if (hdr_idx < 4'd8) begin
            case (hdr_idx[2:0])
                HDR_VERSION: begin
                    if (b != FCGI_VERSION) begin
                        halted = 1'b1;
                        cls = CLS_HALTED;
                    end else begin
                        cur_type = '0;
                        cur_id = '0;
                        content_left = '0;
                        pad_left = '0;
                    end
                end
                HDR_TYPE:    cur_type = b;
                HDR_ID_HI:   cur_id = {b, 8'h00};
                HDR_ID_LO:   cur_id[7:0] = b;
                HDR_LEN_HI:  content_left = {b, 8'h00};
                HDR_LEN_LO:  content_left[7:0] = b;
                HDR_PADDING: pad_left = b;
                HDR_RESERVED: begin
                    phase = PH_NAME_LEN;
                    len_seen = '0;
                    len_acc = '0;
                    name_left = '0;
                    value_left = '0;
                    key_len = '0;
                    value_len = '0;
                    body_idx = '0;
                    role_acc = '0;
                    keep = 1'b0;
                    empty_body = content_left == 0;
                    hit = 1'b0;
                    for (int i = N_SLOTS - 1; i >= 0; i--) begin
                        if (entry_valid[i] && entry_id[i] == cur_id) begin
                            hit = 1'b1;
                            cur_slot = 3'(i);
                        end
                    end
                    if (!hit) begin
                        f = free_slot();
                        cur_slot = f < 0 ? 3'd0 : 3'(f);
                    end
                    ends = content_left == 0 && pad_left == 0;
                end
                default: ;
            endcase
            if (!halted) hdr_idx++;
        end else begin
            if (content_left > 0) begin
                case (cur_type)
                    REC_BEGIN: begin
                        cls = CLS_BEGIN_BODY;
                        if (body_idx == BODY_ROLE_HI) role_acc = {b, 8'h00};
                        else if (body_idx == BODY_ROLE_LO) role_acc[7:0] = b;
                        else if (body_idx == BODY_FLAGS) keep = b[0];
                        if (body_idx != BODY_LAST) body_idx++;
                    end
                    REC_PARAMS: begin
                        if (!hit) begin
                            cls = CLS_IGNORED;
                        end else if (phase == PH_NAME) begin
                            cls = CLS_NAME;
                            name_left--;
                            if (name_left == 0)
                                phase = value_left != 0 ? PH_VALUE : PH_NAME_LEN;
                        end else if (phase == PH_VALUE) begin
                            cls = CLS_VALUE;
                            value_left--;
                            if (value_left == 0) phase = PH_NAME_LEN;
                        end else begin
                            cls = phase == PH_NAME_LEN ? CLS_NAME_LEN : CLS_VALUE_LEN;
                            if (len_seen == 0 && !b[7]) begin
                                val = 31'(b);
                                complete = 1'b1;
                            end else if (len_seen == 0) begin
                                len_acc = {25'd0, b[6:0]};
                                len_seen = 2'd1;
                            end else begin
                                len_acc = {1'b0, len_acc[22:0], b};
                                if (len_seen == 2'd3) begin
                                    val = len_acc[30:0];
                                    complete = 1'b1;
                                    len_seen = '0;
                                end else begin
                                    len_seen++;
                                end
                            end
                            if (complete) begin
                                if (phase == PH_NAME_LEN) begin
                                    key_len = val;
                                    name_left = val;
                                    value_len = '0;
                                    phase = PH_VALUE_LEN;
                                end else begin
                                    value_len = val;
                                    value_left = val;
                                    phase = name_left != 0 ? PH_NAME :
                                            value_left != 0 ? PH_VALUE : PH_NAME_LEN;
                                end
                            end
                        end
                    end
                    REC_STDIN: cls = hit ? CLS_STDIN : CLS_IGNORED;
                    default:   cls = CLS_IGNORED;
                endcase
                content_left--;
            end else begin
                cls = CLS_PADDING;
                if (pad_left > 0) pad_left--;
            end
            ends = content_left == 0 && pad_left == 0;
        end

        if (ends) begin
            case (cur_type)
                REC_BEGIN: begin
                    if (hit) begin
                        entry_valid[cur_slot] = 1'b0;
                        evt = EVT_DUPLICATE;
                    end else begin
                        f = free_slot();
                        if (f < 0) begin
                            evt = EVT_FULL;
                        end else begin
                            cur_slot = 3'(f);
                            entry_valid[f] = 1'b1;
                            entry_id[f] = cur_id;
                            evt = EVT_BEGUN;
                        end
                    end
                end
                REC_ABORT:  evt = hit ? EVT_ABORTED : EVT_UNK_ID;
                REC_PARAMS: evt = !hit ? EVT_UNK_ID : empty_body ? EVT_PARAMS_END : EVT_PARAMS;
                REC_STDIN:  evt = !hit ? EVT_UNK_ID : empty_body ? EVT_STDIN_END : EVT_STDIN;
                default:    evt = EVT_UNK_TYPE;
            endcase
            hdr_idx = '0;
        end

        r.byte_class    = cls;
        r.record_type   = cur_type;
        r.request_id    = cur_id;
        r.byte_out      = b;
        r.name_length   = halted ? '0 : key_len;
        r.value_length  = halted ? '0 : value_len;
        r.record_done   = ends;
        r.record_event  = evt;
        r.slot          = halted || evt == EVT_FULL || evt == EVT_UNK_TYPE ||
                          evt == EVT_UNK_ID ? 3'd0 : cur_slot;
        r.role          = halted ? '0 : role_acc;
        r.keep_conn     = halted ? 1'b0 : keep;
        r.version_error = halted;
        return r;
    endfunction

    bit in_burst;

    task automatic send_byte(input stim_row_t row);
        int          gap;
        rdf_result_t want;
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.data;
        do @(posedge aclk); while (!s_tready);
        want = parse_byte(row.data);
        if (row.typed) begin
            want.byte_class   = row.cls;
            want.record_done  = row.last;
            want.record_event = row.evt;
        end
        pending_results.push_back(want);
    endtask

    function automatic logic [30:0] pick_len();
        if ($urandom_range(0, 3) == 0) return '0;
        return 31'($urandom_range(1, 6));
    endfunction

    function automatic void push_len(inout logic [7:0] q [$], input logic [30:0] len);
        if (len < 128 && $urandom_range(0, 2) != 0) begin
            q.push_back(len[7:0]);
        end else begin
            q.push_back({1'b1, len[30:24]});
            q.push_back(len[23:16]);
            q.push_back(len[15:8]);
            q.push_back(len[7:0]);
        end
    endfunction

    initial begin
        logic [7:0]  stream [$];
        logic [7:0]  body [$];
        logic [15:0] id_pool [12];
        logic [15:0] id;
        logic [15:0] blen;
        logic [7:0]  typ;
        logic [7:0]  pad;
        logic [7:0]  bad;
        logic [30:0] nlen;
        logic [30:0] vlen;
        bit          cut;
        int          pick;
        int          pairs;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        hdr_idx = '0;
        cur_type = '0;
        cur_id = '0;
        content_left = '0;
        pad_left = '0;
        phase = PH_NAME_LEN;
        len_acc = '0;
        len_seen = '0;
        name_left = '0;
        value_left = '0;
        key_len = '0;
        value_len = '0;
        body_idx = '0;
        role_acc = '0;
        keep = 1'b0;
        halted = 1'b0;
        cur_slot = '0;
        hit = 1'b0;
        empty_body = 1'b0;
        for (int i = 0; i < N_SLOTS; i++) entry_valid[i] = 1'b0;
        fail_count = 0;
        in_burst = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_OPENING; i++) send_byte(OPENING[i]);

        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 12; i++) id_pool[i] = 16'($urandom);

        while (stream.size() < RANDOM_BYTES) begin
            body.delete();
            id = $urandom_range(0, 99) < 85 ? id_pool[$urandom_range(0, 11)] : 16'($urandom);
            pad = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 7)) : 8'd0;
            if ($urandom_range(0, 49) == 0) pad = 8'($urandom_range(200, 255));
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                typ = REC_BEGIN;
                id = id_pool[$urandom_range(0, 11)];
                if ($urandom_range(0, 4) != 0) begin
                    repeat (8) body.push_back(8'($urandom));
                end else begin
                    repeat ($urandom_range(0, 11)) body.push_back(8'($urandom));
                end
            end else if (pick < 50) begin
                typ = REC_PARAMS;
                if ($urandom_range(0, 4) != 0) begin
                    pairs = $urandom_range(1, 3);
                    cut = 1'b0;
                    for (int p = 0; p < pairs && !cut; p++) begin
                        nlen = pick_len();
                        vlen = pick_len();
                        // oversized length: the record ends inside the string
                        if ($urandom_range(0, 11) == 0) begin
                            nlen = 31'($urandom);
                            cut = 1'b1;
                        end
                        push_len(body, nlen);
                        push_len(body, vlen);
                        if (cut) begin
                            repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
                        end else begin
                            repeat (nlen) body.push_back(8'($urandom));
                            repeat (vlen) body.push_back(8'($urandom));
                        end
                    end
                    if ($urandom_range(0, 7) == 0)
                        body = body[0:$urandom_range(0, body.size() - 1)];
                    if ($urandom_range(0, 9) == 0)
                        body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
                end
            end else if (pick < 68) begin
                typ = REC_STDIN;
                if ($urandom_range(0, 39) == 0) begin
                    repeat ($urandom_range(256, 300)) body.push_back(8'($urandom));
                end else if ($urandom_range(0, 3) != 0) begin
                    repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
                end
            end else if (pick < 78) begin
                typ = REC_ABORT;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) body.push_back(8'($urandom));
            end else if (pick < 88) begin
                case ($urandom_range(0, 3))
                    0:       typ = 8'd0;
                    1:       typ = 8'd3;
                    default: typ = 8'($urandom_range(6, 255));
                endcase
                repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0:       typ = REC_ABORT;
                    1:       typ = REC_PARAMS;
                    default: typ = REC_STDIN;
                endcase
                id = 16'($urandom);
                repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
            end
            blen = 16'(body.size());
            stream.push_back(FCGI_VERSION);
            stream.push_back(typ);
            stream.push_back(id[15:8]);
            stream.push_back(id[7:0]);
            stream.push_back(blen[15:8]);
            stream.push_back(blen[7:0]);
            stream.push_back(pad);
            stream.push_back(8'($urandom));
            foreach (body[i]) stream.push_back(body[i]);
            repeat (pad) stream.push_back(8'($urandom));
        end

        // bad version halts the parser for the rest of the run
        bad = 8'($urandom_range(2, 255));
        if ($urandom_range(0, 3) == 0) bad = 8'd0;
        stream.push_back(bad);
        repeat (8) stream.push_back(8'($urandom));

        foreach (stream[i]) send_byte('{stream[i], 1'b0, CLS_HEADER, 1'b0, EVT_NONE});
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Checked %0d streamed bytes, %0d records closed before the version halt.",
                 bytes_checked, records_closed);
        $display("Record events observed: begun %0b dup %0b full %0b abort %0b params %0b/%0b",
                 events_seen[EVT_BEGUN], events_seen[EVT_DUPLICATE], events_seen[EVT_FULL],
                 events_seen[EVT_ABORTED], events_seen[EVT_PARAMS], events_seen[EVT_PARAMS_END]);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    initial begin
        rdf_result_t want;
        bit          out_burst;
        int          stall;
        out_burst = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: byte_out %0d", m_tdata[31:24]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                bytes_checked++;
                if (m_tlast) records_closed++;
                events_seen[m_tdata[97:94]] = 1'b1;
                check_field("byte_class", 32'(want.byte_class), 32'(m_tuser));
                check_field("record_type", 32'(want.record_type), 32'(m_tdata[7:0]));
                check_field("request_id", 32'(want.request_id), 32'(m_tdata[23:8]));
                check_field("byte_out", 32'(want.byte_out), 32'(m_tdata[31:24]));
                check_field("name_length", 32'(want.name_length), 32'(m_tdata[62:32]));
                check_field("value_length", 32'(want.value_length), 32'(m_tdata[93:63]));
                check_field("record_done", 32'(want.record_done), 32'(m_tlast));
                check_field("record_event", 32'(want.record_event), 32'(m_tdata[97:94]));
                check_field("slot", 32'(want.slot), 32'(m_tdata[100:98]));
                check_field("role", 32'(want.role), 32'(m_tdata[116:101]));
                check_field("keep_conn", 32'(want.keep_conn), 32'(m_tdata[117]));
                check_field("version_error", 32'(want.version_error),
                            32'(m_tdata[OUT_VERR_BIT]));
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
